[rtl/core/mtq_pkg.sv]
// Shared types and constants for the matrix-to-quaternion core.
// No dependencies; imported by every module of the block.
package mtq_pkg;

  localparam int ArgW  = 17;  // square-root argument, raw Q2.14, always below 7.0
  localparam int MagW  = 17;  // magnitude of an off-diagonal sum or difference
  localparam int RootW = 15;  // floor(sqrt(arg * 4096))
  localparam int SqN   = 30;  // radicand width, even
  localparam int RemSW = 17;  // square-root partial remainder
  localparam int DivW  = 16;  // divisor, twice the root
  localparam int NumW  = 31;  // mag * 8192 + root
  localparam int QuoW  = 17;  // quotient bits, one per divider stage
  localparam int Lanes = 3;

  typedef enum logic [1:0] {
    PickTrace,
    PickX,
    PickY,
    PickZ
  } pick_e;

  typedef struct packed {
    pick_e                        pick;
    logic [ArgW-1:0]              arg;
    logic [Lanes-1:0][MagW-1:0]   mag;
    logic [Lanes-1:0]             neg;
  } job_t;

  typedef struct packed {
    pick_e                        pick;
    logic [SqN-1:0]               n;
    logic [RemSW-1:0]             rem;
    logic [RootW-1:0]             root;
    logic [Lanes-1:0][MagW-1:0]   mag;
    logic [Lanes-1:0]             neg;
  } sq_t;

  typedef struct packed {
    pick_e                        pick;
    logic [RootW-1:0]             root;
    logic [DivW-1:0]              div;
    logic [Lanes-1:0][NumW-1:0]   num;
    logic [Lanes-1:0][DivW-1:0]   rem;
    logic [Lanes-1:0][QuoW-1:0]   quo;
    logic [Lanes-1:0]             neg;
  } dv_t;

  // Apply sign and clamp to the Q2.14 range.
  function automatic logic [15:0] sat_q(input logic [QuoW-1:0] quo, input logic neg);
    logic [QuoW-1:0] neg_v;
    neg_v = ~quo + QuoW'(1);
    if (!neg) begin
      sat_q = (quo > QuoW'(32767)) ? 16'h7fff : quo[15:0];
    end else begin
      sat_q = (quo > QuoW'(32768)) ? 16'h8000 : neg_v[15:0];
    end
  endfunction

endpackage

[rtl/core/mtq_front.sv]
// Front end: classifies a matrix (trace or largest diagonal) and forms the
// square-root argument and off-diagonal magnitudes. Depends on mtq_pkg.
module mtq_front import mtq_pkg::*; (
  input  logic signed [15:0] m00_i,
  input  logic signed [15:0] m01_i,
  input  logic signed [15:0] m02_i,
  input  logic signed [15:0] m10_i,
  input  logic signed [15:0] m11_i,
  input  logic signed [15:0] m12_i,
  input  logic signed [15:0] m20_i,
  input  logic signed [15:0] m21_i,
  input  logic signed [15:0] m22_i,
  output job_t               job_o
);

  logic signed [18:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
  logic signed [18:0] tr, arg_v, sel;
  logic signed [18:0] d [Lanes];
  pick_e pick;

  always_comb begin
    a00 = 19'(m00_i); a01 = 19'(m01_i); a02 = 19'(m02_i);
    a10 = 19'(m10_i); a11 = 19'(m11_i); a12 = 19'(m12_i);
    a20 = 19'(m20_i); a21 = 19'(m21_i); a22 = 19'(m22_i);
    tr  = a00 + a11 + a22;
    sel = a00;
    pick = PickX;
    if (tr > 19'sd0) begin
      pick = PickTrace;
    end else begin
      // strict compares: ties keep the lower index
      if (a00 < a11) begin
        pick = PickY;
        sel  = a11;
      end
      if (sel < a22) pick = PickZ;
    end
  end

  always_comb begin
    unique case (pick)
      PickTrace: begin
        arg_v = tr + 19'sd16384;
        d[0] = a21 - a12; d[1] = a02 - a20; d[2] = a10 - a01;
      end
      PickX: begin
        arg_v = a00 - (a11 + a22) + 19'sd16384;
        d[0] = a21 - a12; d[1] = a10 + a01; d[2] = a20 + a02;
      end
      PickY: begin
        arg_v = a11 - (a22 + a00) + 19'sd16384;
        d[0] = a02 - a20; d[1] = a21 + a12; d[2] = a01 + a10;
      end
      PickZ: begin
        arg_v = a22 - (a00 + a11) + 19'sd16384;
        d[0] = a10 - a01; d[1] = a02 + a20; d[2] = a12 + a21;
      end
      default: begin
        arg_v = 19'sd16384;
        d[0] = '0; d[1] = '0; d[2] = '0;
      end
    endcase
  end

  always_comb begin
    job_o.pick = pick;
    job_o.arg  = arg_v[ArgW-1:0];
    for (int j = 0; j < Lanes; j++) begin
      logic signed [18:0] mag_v;
      mag_v = d[j][18] ? -d[j] : d[j];
      job_o.neg[j] = d[j][18];
      job_o.mag[j] = mag_v[MagW-1:0];
    end
  end

endmodule

[rtl/core/mtq_queue.sv]
// Short item queue between the front end and the arithmetic back end.
// Depends on mtq_pkg for the job type.
module mtq_queue import mtq_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  job_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    if (do_pop)  rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    else if (!do_push && do_pop) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= job_i;
  end

endmodule

[rtl/core/mtq_back.sv]
// Back end: pipelined square root (one root bit per stage), three pipelined
// restoring dividers (one quotient bit per stage), saturation and output register.
// Depends on mtq_pkg.
module mtq_back import mtq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  job_t               job_i,
  output logic               job_pop_o,
  input  logic               pop,
  output logic               empty,
  output logic signed [15:0] qx_o,
  output logic signed [15:0] qy_o,
  output logic signed [15:0] qz_o,
  output logic signed [15:0] qw_o
);

  sq_t  sq_q [RootW];
  logic sq_v_q [RootW];
  dv_t  dv_q [QuoW];
  logic dv_v_q [QuoW];
  logic out_v_q;
  logic [15:0] qx_q, qy_q, qz_q, qw_q;
  logic adv;

  // whole pipeline moves together unless the finished item is not taken
  assign adv       = !out_v_q || pop;
  assign job_pop_o = adv && job_valid_i;

  for (genvar k = 0; k < RootW; k++) begin : g_sq
    localparam int Hi = SqN - 1 - 2 * k;
    sq_t  prev, nxt;
    logic pv;
    if (k == 0) begin : g_first
      always_comb begin
        prev.pick = job_i.pick;
        prev.n    = SqN'({job_i.arg, 12'b0});
        prev.rem  = '0;
        prev.root = '0;
        prev.mag  = job_i.mag;
        prev.neg  = job_i.neg;
        pv        = job_valid_i;
      end
    end else begin : g_rest
      assign prev = sq_q[k-1];
      assign pv   = sq_v_q[k-1];
    end
    always_comb begin
      logic [RemSW+1:0] r2, trial;
      r2    = {prev.rem, prev.n[Hi -: 2]};
      trial = (RemSW + 2)'({prev.root, 2'b01});
      nxt   = prev;
      if (r2 >= trial) begin
        nxt.rem  = RemSW'(r2 - trial);
        nxt.root = {prev.root[RootW-2:0], 1'b1};
      end else begin
        nxt.rem  = r2[RemSW-1:0];
        nxt.root = {prev.root[RootW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sq_v_q[k] <= 1'b0;
      else if (adv) sq_v_q[k] <= pv;
    end
    always_ff @(posedge clk_i) begin
      if (adv) sq_q[k] <= nxt;
    end
  end

  for (genvar k = 0; k < QuoW; k++) begin : g_dv
    localparam int Bit = QuoW - 1 - k;
    dv_t  prev, nxt;
    logic pv;
    if (k == 0) begin : g_first
      always_comb begin
        prev.pick = sq_q[RootW-1].pick;
        prev.root = sq_q[RootW-1].root;
        prev.div  = {sq_q[RootW-1].root, 1'b0};
        prev.neg  = sq_q[RootW-1].neg;
        for (int j = 0; j < Lanes; j++) begin
          prev.num[j] = NumW'({sq_q[RootW-1].mag[j], 13'b0}) + NumW'(sq_q[RootW-1].root);
          prev.rem[j] = DivW'(prev.num[j][NumW-1:QuoW]);
          prev.quo[j] = '0;
        end
        pv = sq_v_q[RootW-1];
      end
    end else begin : g_rest
      assign prev = dv_q[k-1];
      assign pv   = dv_v_q[k-1];
    end
    always_comb begin
      nxt = prev;
      for (int j = 0; j < Lanes; j++) begin
        logic [DivW:0] r2;
        r2 = {prev.rem[j], prev.num[j][Bit]};
        if (r2 >= {1'b0, prev.div}) begin
          nxt.rem[j] = DivW'(r2 - {1'b0, prev.div});
          nxt.quo[j] = {prev.quo[j][QuoW-2:0], 1'b1};
        end else begin
          nxt.rem[j] = r2[DivW-1:0];
          nxt.quo[j] = {prev.quo[j][QuoW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v_q[k] <= 1'b0;
      else if (adv) dv_v_q[k] <= pv;
    end
    always_ff @(posedge clk_i) begin
      if (adv) dv_q[k] <= nxt;
    end
  end

  logic [15:0] c0, c1, c2, hv, qx_d, qy_d, qz_d, qw_d;
  always_comb begin
    c0 = sat_q(dv_q[QuoW-1].quo[0], dv_q[QuoW-1].neg[0]);
    c1 = sat_q(dv_q[QuoW-1].quo[1], dv_q[QuoW-1].neg[1]);
    c2 = sat_q(dv_q[QuoW-1].quo[2], dv_q[QuoW-1].neg[2]);
    hv = 16'(dv_q[QuoW-1].root);
    unique case (dv_q[QuoW-1].pick)
      PickTrace: begin qw_d = hv; qx_d = c0; qy_d = c1; qz_d = c2; end
      PickX:     begin qx_d = hv; qw_d = c0; qy_d = c1; qz_d = c2; end
      PickY:     begin qy_d = hv; qw_d = c0; qz_d = c1; qx_d = c2; end
      PickZ:     begin qz_d = hv; qw_d = c0; qx_d = c1; qy_d = c2; end
      default:   begin qx_d = '0; qy_d = '0; qz_d = '0; qw_d = '0; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (adv) out_v_q <= dv_v_q[QuoW-1];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      qx_q <= qx_d;
      qy_q <= qy_d;
      qz_q <= qz_d;
      qw_q <= qw_d;
    end
  end

  assign empty = !out_v_q;
  assign qx_o  = qx_q;
  assign qy_o  = qy_q;
  assign qz_o  = qz_q;
  assign qw_o  = qw_q;

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> out_v_q)
    else $error("result dropped while stalled");

  a_root_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_v_q[RootW-1] |-> sq_q[RootW-1].root >= RootW'(8192))
    else $error("square root below 0.5");

  a_root_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_v_q[RootW-1] |->
      (32'(sq_q[RootW-1].root) * 32'(sq_q[RootW-1].root) <= 32'(sq_q[RootW-1].n)) &&
      ((32'(sq_q[RootW-1].root) + 32'd1) * (32'(sq_q[RootW-1].root) + 32'd1)
        > 32'(sq_q[RootW-1].n)))
    else $error("square root is not the floor");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v_q[QuoW-1] |->
      (dv_q[QuoW-1].rem[0] < dv_q[QuoW-1].div) &&
      (dv_q[QuoW-1].rem[1] < dv_q[QuoW-1].div) &&
      (dv_q[QuoW-1].rem[2] < dv_q[QuoW-1].div))
    else $error("divider remainder out of range");

endmodule

[rtl/core/matrix_to_quaternion_core.sv]
// Rotation matrix (Q2.14) to quaternion (Q2.14) converter.
// A result reaches the output ports through one queue slot, the 15-stage square root and
// the 17-stage dividers, and waits there until popped. Throughput: one item per cycle; an
// unpopped result stalls the pipeline.
// Reset clears the queue and all pipeline valid bits; payload registers are not reset.
// Depends on mtq_pkg, mtq_front, mtq_queue and mtq_back.
module matrix_to_quaternion_core import mtq_pkg::*; #(
  parameter int QueueDepth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] m00_i,
  input  logic signed [15:0] m01_i,
  input  logic signed [15:0] m02_i,
  input  logic signed [15:0] m10_i,
  input  logic signed [15:0] m11_i,
  input  logic signed [15:0] m12_i,
  input  logic signed [15:0] m20_i,
  input  logic signed [15:0] m21_i,
  input  logic signed [15:0] m22_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] qx_o,
  output logic signed [15:0] qy_o,
  output logic signed [15:0] qz_o,
  output logic signed [15:0] qw_o
);

  job_t front_job, head_job;
  logic head_valid, head_pop;

  mtq_front u_front (
    .m00_i, .m01_i, .m02_i,
    .m10_i, .m11_i, .m12_i,
    .m20_i, .m21_i, .m22_i,
    .job_o (front_job)
  );

  mtq_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .job_i   (front_job),
    .full_o  (full),
    .pop_i   (head_pop),
    .valid_o (head_valid),
    .job_o   (head_job)
  );

  mtq_back u_back (
    .clk_i,
    .rst_ni,
    .job_valid_i (head_valid),
    .job_i       (head_job),
    .job_pop_o   (head_pop),
    .pop,
    .empty,
    .qx_o,
    .qy_o,
    .qz_o,
    .qw_o
  );

endmodule

[bench/tb_matrix_to_quaternion_core.sv]
// Testbench for matrix_to_quaternion_core: random and directed matrices,
// predicted quaternions checked in order by a small scoreboard class.
// Depends on the core RTL only.
module tb_matrix_to_quaternion_core;

  typedef logic signed [15:0] q14_t;

  typedef struct packed {
    q14_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } mat_t;

  typedef struct packed {
    q14_t x, y, z, w;
  } quat_t;

  function automatic logic [31:0] root_floor(input logic [31:0] n);
    logic [31:0] res, bitv, rem;
    res = 0;
    bitv = 32'h4000_0000;
    rem = n;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic q14_t clamp_q14(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return q14_t'(v);
  endfunction

  // d * 4096 / h, rounded half away from zero
  function automatic q14_t scale_pair(input int d, input longint h);
    longint mag, q;
    mag = (d < 0) ? -longint'(d) : longint'(d);
    q = (mag * 8192 + h) / (2 * h);
    return clamp_q14((d < 0) ? -q : q);
  endfunction

  function automatic quat_t quat_of(input mat_t m);
    int a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, arg, pick;
    longint h;
    quat_t q;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    tr = a00 + a11 + a22;
    if (tr > 0) begin
      arg = tr + 16384;
      h = root_floor(arg * 4096);
      q.w = clamp_q14(h);
      q.x = scale_pair(a21 - a12, h);
      q.y = scale_pair(a02 - a20, h);
      q.z = scale_pair(a10 - a01, h);
    end else begin
      pick = 0;
      if (a00 < a11) pick = 1;
      if (((pick == 0) ? a00 : a11) < a22) pick = 2;
      if (pick == 0) begin
        arg = a00 - (a11 + a22) + 16384;
        h = root_floor(arg * 4096);
        q.x = clamp_q14(h);
        q.w = scale_pair(a21 - a12, h);
        q.y = scale_pair(a10 + a01, h);
        q.z = scale_pair(a20 + a02, h);
      end else if (pick == 1) begin
        arg = a11 - (a22 + a00) + 16384;
        h = root_floor(arg * 4096);
        q.y = clamp_q14(h);
        q.w = scale_pair(a02 - a20, h);
        q.z = scale_pair(a21 + a12, h);
        q.x = scale_pair(a01 + a10, h);
      end else begin
        arg = a22 - (a00 + a11) + 16384;
        h = root_floor(arg * 4096);
        q.z = clamp_q14(h);
        q.w = scale_pair(a10 - a01, h);
        q.x = scale_pair(a02 + a20, h);
        q.y = scale_pair(a12 + a21, h);
      end
    end
    return q;
  endfunction

  class quat_scoreboard;
    quat_t pending[$];
    int errors = 0;

    function void note_matrix(mat_t m);
      pending.push_back(quat_of(m));
    endfunction

    function void check_quat(quat_t got);
      quat_t exp_q;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_q = pending.pop_front();
      if (got !== exp_q) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp x=%h y=%h z=%h w=%h got x=%h y=%h z=%h w=%h",
                   exp_q.x, exp_q.y, exp_q.z, exp_q.w, got.x, got.y, got.z, got.w);
      end
    endfunction
  endclass

  localparam int NumRandom = 800;
  localparam int StallLimit = 2000;

  logic clk_i, rst_ni, push, full, empty, pop;
  mat_t mat;
  logic signed [15:0] qx_o, qy_o, qz_o, qw_o;
  quat_scoreboard board;
  bit quiet;
  int idle_cycles;

  matrix_to_quaternion_core i_dut (
    .clk_i, .rst_ni, .push, .full,
    .m00_i(mat.m00), .m01_i(mat.m01), .m02_i(mat.m02),
    .m10_i(mat.m10), .m11_i(mat.m11), .m12_i(mat.m12),
    .m20_i(mat.m20), .m21_i(mat.m21), .m22_i(mat.m22),
    .empty, .pop, .qx_o, .qy_o, .qz_o, .qw_o
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic q14_t rand_entry();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return q14_t'($urandom_range(0, 32768) - 16384);
      default: return q14_t'($urandom);
    endcase
  endfunction

  // Random signed entries, sometimes with tied diagonals, so every pick path is reached.
  function automatic mat_t rand_matrix();
    mat_t m;
    m = {9{16'sh0}};
    m.m00 = rand_entry(); m.m01 = rand_entry(); m.m02 = rand_entry();
    m.m10 = rand_entry(); m.m11 = rand_entry(); m.m12 = rand_entry();
    m.m20 = rand_entry(); m.m21 = rand_entry(); m.m22 = rand_entry();
    if ($urandom_range(0, 3) == 0) begin
      m.m11 = m.m00;
      if ($urandom_range(0, 1)) m.m22 = m.m00;
    end
    return m;
  endfunction

  task automatic send_matrix(input mat_t m);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    mat <= m;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    board.note_matrix(m);
  endtask

  // Result side: bursty stalls on pop, checked at the accepting edge.
  initial begin
    int stall;
    pop = 1'b0;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) board.check_quat({qx_o, qy_o, qz_o, qw_o});
      if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 4);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted item or result.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    mat_t m;
    q14_t ext[4];
    board = new();
    quiet = 0;
    push = 1'b0;
    mat = '0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    ext = '{16'sh7fff, 16'sh8000, 16'sh0, 16'sh4000};
    // identity, zero trace, ties, extremes
    send_matrix({16'sh4000, 16'sh0, 16'sh0, 16'sh0, 16'sh4000, 16'sh0, 16'sh0, 16'sh0, 16'sh4000});
    send_matrix({9{16'sh0}});
    send_matrix({16'shc000, 16'sh0, 16'sh0, 16'sh0, 16'sh4000, 16'sh0, 16'sh0, 16'sh0, 16'sh0});
    send_matrix({16'shc000, 16'sh0, 16'sh0, 16'sh0, 16'shc000, 16'sh0, 16'sh0, 16'sh0, 16'sh4000});
    send_matrix({16'shc000, 16'sh0, 16'sh0, 16'sh0, 16'shc000, 16'sh0, 16'sh0, 16'sh0, 16'shc000});
    send_matrix({16'sh4000, 16'sh0, 16'sh0, 16'sh0, 16'shc000, 16'sh0, 16'sh0, 16'sh0, 16'shc000});
    send_matrix({16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh4000, 16'sh0, 16'sh0, 16'sh0, 16'shc000});
    foreach (ext[i]) begin
      send_matrix({9{ext[i]}});
      m = {9{ext[i]}};
      m.m00 = 16'sh8000; m.m11 = 16'sh8000; m.m22 = 16'sh8000;
      send_matrix(m);
    end
    send_matrix({16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
    send_matrix({16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
                 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000});
    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom - 100) quiet = 1;
      send_matrix(rand_matrix());
    end
    push <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
